/* sv/gwnn_pkg.sv */
// Shared widths and register codes for the grid window nearest node search.
`timescale 1ns / 1ps
package gwnn_pkg;

  localparam int GS_W      = 16;               // grid_size register
  localparam int GC_W      = 8;                // grid_count register
  localparam int NC_W      = 11;               // node_count register
  localparam int FRAC_BITS = 4;                // Q20.4 fraction bits
  localparam int DIV_W     = GS_W + FRAC_BITS; // cell edge in raw units
  localparam int IDX_W     = 10;               // node_index / nearest_index
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_TDATA_W = 16;             // nearest_index, found, padding

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GRID_SIZE  = 2'd0;
  localparam cfg_idx_t CFG_GRID_COUNT = 2'd1;
  localparam cfg_idx_t CFG_NODE_COUNT = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

/* sv/gwnn_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module gwnn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/grid_window_nearest_node.sv */
// Nearest live node inside a square grid window around a query position.
`timescale 1ns / 1ps
// A write item (cmd 0) stores one node's position and dead mark at node_index in a
// node memory; a write with node_index at or above MAX_NODES is dropped. A query
// item (cmd 1) finds the query's grid cell in x and y by truncating division of
// the raw Q20.4 coordinate by grid_size*16, forms a window of grid_count cells per
// side starting (grid_count-1)/2 cells below that cell, and returns the
// lowest-index live node among entries 0 .. node_count-1 (clamped to MAX_NODES)
// whose cell lies in the window and whose exact squared 3D distance to the query
// is least. found is 0 (and nearest_index 0) when nothing qualifies. For each of
// x and y a bit-serial divider finds the query cell, then the CELL, LOB and HIB
// steps turn the cell window into raw coordinate bounds; the scan reads the simple
// dual-port node memory one entry per cycle through a four-stage distance
// pipeline. With grid_count 0 or node_count 0 the scan is skipped. The block takes
// one item at a time; a finished result waits in the output register while the
// next item is already accepted. Table entries hold nothing until written, so no
// clearing pass runs after reset; querying over unwritten entries gives undefined
// results. Write configuration only while the block is idle.
module grid_window_nearest_node #(
  parameter int MAX_NODES  = 1024,
  parameter int COORD_BITS = 24,
  localparam int IN_TDATA_W = ((gwnn_pkg::IDX_W + 3 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_TDATA_W-1:0]             in_tdata,  // node_index, pos_x, pos_y,
                                                       // pos_z, dead, zero fill
  input  logic [0:0]                        in_tuser,  // cmd
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gwnn_pkg::OUT_TDATA_W-1:0]  out_tdata, // nearest_index, found, zero fill
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  gwnn_pkg::cfg_idx_t                cfg_index,
  input  logic [gwnn_pkg::CFG_DAT_W-1:0]    cfg_data
);

  import gwnn_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW     = $clog2(MAX_NODES + 1);     // node counter, holds MAX_NODES
  localparam int RW     = 3 * CB + 1;                // memory word: x, y, z, dead
  localparam int DCW    = $clog2(CB + 1);            // divider step counter
  localparam int CELL_W = CB + 2;                    // window cell indexes
  localparam int PW     = CELL_W + DIV_W + 1;        // cell * edge product
  localparam int BW     = ((CB > 28) ? CB : 28) + 2; // raw window bounds
  localparam int DX_W   = CB + 1;                    // coordinate difference
  localparam int PRD_W  = 2 * DX_W;
  localparam int SQ_W   = 2 * CB;                    // one squared difference
  localparam int SUM_W  = 2 * CB + 2;                // squared distance

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_LOB   = 3'd3;
  localparam logic [2:0] S_HIB   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // ---------------------------------------------------------------- input fields
  logic [IDX_W-1:0]     in_node_index;
  logic signed [CB-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic                 in_dead, in_cmd;

  assign in_node_index = in_tdata[IDX_W-1:0];
  assign in_pos_x      = in_tdata[IDX_W +: CB];
  assign in_pos_y      = in_tdata[IDX_W + CB +: CB];
  assign in_pos_z      = in_tdata[IDX_W + 2 * CB +: CB];
  assign in_dead       = in_tdata[IDX_W + 3 * CB];
  assign in_cmd        = in_tuser[0];

  // ---------------------------------------------------------------- configuration
  logic [GS_W-1:0] grid_size_r;
  logic [GC_W-1:0] grid_count_r;
  logic [NC_W-1:0] node_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= GS_W'(1);
      grid_count_r <= GC_W'(1);
      node_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_SIZE:  grid_size_r  <= cfg_data[GS_W-1:0];
        CFG_GRID_COUNT: grid_count_r <= cfg_data[GC_W-1:0];
        CFG_NODE_COUNT: node_count_r <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective edge length in raw units and clamped node count
  logic [DIV_W-1:0] edge_eff;
  logic [CW-1:0]    n_eff;

  assign edge_eff = {((grid_size_r == '0) ? GS_W'(1) : grid_size_r), {FRAC_BITS{1'b0}}};
  assign n_eff    = (32'(node_count_r) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(node_count_r);

  // ---------------------------------------------------------------- registers
  logic [2:0]              state_r, state_nxt;
  logic                    axis_r, axis_nxt;       // 0: x, 1: y
  logic signed [CB-1:0]    qx_r, qy_r, qz_r, qx_nxt, qy_nxt, qz_nxt;
  logic [DIV_W-1:0]        d_r, d_nxt;
  logic [GC_W-1:0]         gc_r, gc_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [CB-1:0]           num_r, num_nxt;         // dividend, then quotient
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic                    neg_r, neg_nxt;
  logic [DCW-1:0]          cnt_r, cnt_nxt;
  logic signed [CELL_W-1:0] lcell_r, hcell_r, lcell_nxt, hcell_nxt;
  logic signed [BW-1:0]    lox_r, hix_r, loy_r, hiy_r;
  logic signed [BW-1:0]    lox_nxt, hix_nxt, loy_nxt, hiy_nxt;
  logic [CW-1:0]           scan_cnt_r, scan_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_found_r, out_found_nxt;

  logic                    have_r;
  logic [AW-1:0]           best_idx_r;
  logic [SUM_W-1:0]        best_sum_r;

  // scan pipeline
  logic                    s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [AW-1:0]           s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic                    s2_hit_r, s3_hit_r, s4_hit_r;
  logic signed [DX_W-1:0]  s2_dx_r, s2_dy_r, s2_dz_r;
  logic [SQ_W-1:0]         s3_sqx_r, s3_sqy_r, s3_sqz_r;
  logic [SUM_W-1:0]        s4_sum_r;

  // ---------------------------------------------------------------- node memory
  logic           in_xfer, ram_we, ram_re, q_start;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign q_start   = in_xfer && (in_cmd == CMD_QUERY);
  // drop writes beyond the table
  assign ram_we    = in_xfer && (in_cmd == CMD_WRITE)
                     && (32'(in_node_index) < 32'(MAX_NODES));
  assign ram_waddr = AW'(in_node_index);
  assign ram_wdata = {in_dead, in_pos_z, in_pos_y, in_pos_x};
  assign ram_re    = (state_r == S_SCAN);
  assign ram_raddr = scan_cnt_r[AW-1:0];

  gwnn_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- divider step
  // Restoring division, one quotient bit per cycle; rem stays below the divisor.
  logic [DIV_W:0]   div_trial;
  logic             div_ge;
  logic [DIV_W-1:0] div_rem;

  assign div_trial = {rem_r, num_r[CB-1]};
  assign div_ge    = (div_trial >= {1'b0, d_r});
  assign div_rem   = div_ge ? DIV_W'(div_trial - {1'b0, d_r}) : DIV_W'(div_trial);

  // signed query cell from the quotient magnitude, window corners in cells
  logic signed [CELL_W-1:0] cell_abs, cell_q, cell_lo, cell_hi;
  logic [GC_W-1:0]          half;

  assign cell_abs = CELL_W'($signed({1'b0, num_r}));
  assign cell_q   = neg_r ? -cell_abs : cell_abs;
  assign half     = GC_W'(gc_r - GC_W'(1)) >> 1;
  assign cell_lo  = cell_q - CELL_W'($signed({1'b0, half}));
  assign cell_hi  = cell_lo + CELL_W'($signed({1'b0, gc_r})) - CELL_W'(1);

  // shared multiplier turns a cell index into its raw coordinate
  logic signed [CELL_W-1:0] mul_a;
  logic signed [PW-1:0]     mul_p;
  logic signed [BW-1:0]     prod_b, edge_b;

  assign mul_a  = (state_r == S_LOB) ? lcell_r : hcell_r;
  assign mul_p  = PW'(mul_a) * $signed(PW'({1'b0, d_r}));
  assign prod_b = BW'(mul_p);
  assign edge_b = $signed(BW'({1'b0, d_r}));

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qz_nxt        = qz_r;
    d_nxt         = d_r;
    gc_nxt        = gc_r;
    n_nxt         = n_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    lcell_nxt     = lcell_r;
    hcell_nxt     = hcell_r;
    lox_nxt       = lox_r;
    hix_nxt       = hix_r;
    loy_nxt       = loy_r;
    hiy_nxt       = hiy_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;

    // drop the held result once the consumer takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_start) begin
          qx_nxt  = in_pos_x;
          qy_nxt  = in_pos_y;
          qz_nxt  = in_pos_z;
          d_nxt   = edge_eff;
          gc_nxt  = grid_count_r;
          n_nxt   = n_eff;
          axis_nxt = 1'b0;
          num_nxt = in_pos_x[CB-1] ? CB'(-in_pos_x) : CB'(in_pos_x);
          neg_nxt = in_pos_x[CB-1];
          rem_nxt = '0;
          cnt_nxt = '0;
          // empty window or empty table: nothing to scan
          if (grid_count_r == '0 || n_eff == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = div_rem;
        num_nxt = {num_r[CB-2:0], div_ge};
        cnt_nxt = cnt_r + DCW'(1);
        if (cnt_r == DCW'(CB - 1)) begin
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        lcell_nxt = cell_lo;
        hcell_nxt = cell_hi;
        state_nxt = S_LOB;
      end
      S_LOB: begin
        // lowest raw value whose cell is the window's first cell
        if (lcell_r > CELL_W'(0)) begin
          if (axis_r) loy_nxt = prod_b;
          else        lox_nxt = prod_b;
        end else begin
          if (axis_r) loy_nxt = prod_b - edge_b + BW'(1);
          else        lox_nxt = prod_b - edge_b + BW'(1);
        end
        state_nxt = S_HIB;
      end
      S_HIB: begin
        // highest raw value whose cell is the window's last cell
        if (hcell_r >= CELL_W'(0)) begin
          if (axis_r) hiy_nxt = prod_b + edge_b - BW'(1);
          else        hix_nxt = prod_b + edge_b - BW'(1);
        end else begin
          if (axis_r) hiy_nxt = prod_b;
          else        hix_nxt = prod_b;
        end
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          num_nxt   = qy_r[CB-1] ? CB'(-qy_r) : CB'(qy_r);
          neg_nxt   = qy_r[CB-1];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == n_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = have_r ? IDX_W'(best_idx_r) : '0;
          out_found_nxt = have_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      scan_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    qz_r        <= qz_nxt;
    d_r         <= d_nxt;
    gc_r        <= gc_nxt;
    n_r         <= n_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    neg_r       <= neg_nxt;
    lcell_r     <= lcell_nxt;
    hcell_r     <= hcell_nxt;
    lox_r       <= lox_nxt;
    hix_r       <= hix_nxt;
    loy_r       <= loy_nxt;
    hiy_r       <= hiy_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
  end

  // ---------------------------------------------------------------- scan pipeline
  logic signed [CB-1:0]    rd_x, rd_y, rd_z;
  logic                    rd_dead, rd_hit;
  logic signed [PRD_W-1:0] prd_x, prd_y, prd_z;

  assign rd_x    = ram_rdata[CB-1:0];
  assign rd_y    = ram_rdata[2 * CB - 1:CB];
  assign rd_z    = ram_rdata[3 * CB - 1:2 * CB];
  assign rd_dead = ram_rdata[3 * CB];
  assign rd_hit  = !rd_dead
                   && (BW'(rd_x) >= lox_r) && (BW'(rd_x) <= hix_r)
                   && (BW'(rd_y) >= loy_r) && (BW'(rd_y) <= hiy_r);

  assign prd_x = PRD_W'(s2_dx_r) * PRD_W'(s2_dx_r);
  assign prd_y = PRD_W'(s2_dy_r) * PRD_W'(s2_dy_r);
  assign prd_z = PRD_W'(s2_dz_r) * PRD_W'(s2_dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ram_re;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= ram_raddr;
    // window test and differences
    s2_idx_r <= s1_idx_r;
    s2_hit_r <= rd_hit;
    s2_dx_r  <= DX_W'(qx_r) - DX_W'(rd_x);
    s2_dy_r  <= DX_W'(qy_r) - DX_W'(rd_y);
    s2_dz_r  <= DX_W'(qz_r) - DX_W'(rd_z);
    // squares
    s3_idx_r <= s2_idx_r;
    s3_hit_r <= s2_hit_r;
    s3_sqx_r <= SQ_W'($unsigned(prd_x));
    s3_sqy_r <= SQ_W'($unsigned(prd_y));
    s3_sqz_r <= SQ_W'($unsigned(prd_z));
    // squared distance
    s4_idx_r <= s3_idx_r;
    s4_hit_r <= s3_hit_r;
    s4_sum_r <= SUM_W'(s3_sqx_r) + SUM_W'(s3_sqy_r) + SUM_W'(s3_sqz_r);
  end

  // Keep the first strictly nearer candidate; entries arrive in ascending order,
  // so ties keep the lower index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (q_start) begin
      have_r <= 1'b0;
    end else if (s4_vld_r && s4_hit_r && (!have_r || s4_sum_r < best_sum_r)) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_vld_r && s4_hit_r && (!have_r || s4_sum_r < best_sum_r)) begin
      best_idx_r <= s4_idx_r;
      best_sum_r <= s4_sum_r;
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, out_found_r, out_idx_r};

  // ---------------------------------------------------------------- assertions
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r)
      |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("scan pipeline active outside scan");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r < n_r))
    else $error("scan address beyond node count");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && state_r == S_DONE) |-> (CW'(best_idx_r) < n_r))
    else $error("best index beyond node count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside completion");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the grid window nearest node search block.
`timescale 1ns / 1ps
module tb;
  import gwnn_pkg::*;

  localparam int     MAX_NODES     = 1024;
  localparam int     COORD_BITS    = 24;
  localparam int     IN_W          = ((IDX_W + 3 * COORD_BITS + 1 + 7) / 8) * 8;
  // Allow several times the longer of a full-table query and the long receiver
  // hold-off before calling it a hang.
  localparam int     QUIET_LIMIT   = 20000;
  localparam int     HOLD_CYCLES   = 3000;
  // Writes are stored as soon as they are taken, so a short pause covers any trailing write.
  localparam int     SETTLE_CYCLES = 64;
  localparam longint COORD_MAX     = 64'sd8388607;
  localparam longint COORD_MIN     = -64'sd8388608;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESSURE} idle_mode_t;

  // One input transfer: a node write or a query.
  typedef struct {
    logic                         cmd;
    logic [IDX_W-1:0]             idx;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic                         dead;
  } node_item_t;

  // One result transfer.
  typedef struct {
    logic [IDX_W-1:0] nearest_index;
    logic             found;
  } hit_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata   = '0;  // node_index, pos_x, pos_y, pos_z, dead, zero fill
  logic [0:0]             in_tuser   = '0;  // cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // nearest_index, found, zero fill
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index  = CFG_GRID_SIZE;
  logic [CFG_DAT_W-1:0]   cfg_data   = '0;

  // Items not yet offered, and query answers not yet seen on the output.
  node_item_t items_waiting[$];
  hit_t       hits_due[$];
  node_item_t offered;

  // Node table and registers as the block should hold them.
  longint tbl_x[MAX_NODES];
  longint tbl_y[MAX_NODES];
  longint tbl_z[MAX_NODES];
  bit     tbl_dead[MAX_NODES];
  int     grid_size_r  = 1;
  int     grid_count_r = 1;
  int     node_count_r = 0;

  // Generation side: which entries have a write queued, and their positions.
  bit     written[MAX_NODES];
  longint plan_x[MAX_NODES];
  longint plan_y[MAX_NODES];
  longint plan_z[MAX_NODES];
  longint ctr_x, ctr_y, ctr_z, spread;

  idle_mode_t idle_mode      = IDLE_NONE;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_cnt       = 0;
  bit         hold_done      = 1'b0;
  int         quiet_cycles   = 0;
  int         errors         = 0;

  grid_window_nearest_node #(
    .MAX_NODES (MAX_NODES),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Nearest live node in the window around (qx, qy, qz), lowest index on a tie.
  function automatic hit_t nearest_lookup(longint qx, longint qy, longint qz);
    hit_t   r;
    longint div, gc, half, lox, loy, cx, cy, dx, dy, dz, d2, best;
    int     n;
    bit     have;
    div  = longint'((grid_size_r == 0) ? 1 : grid_size_r) * 16;
    gc   = longint'(grid_count_r);
    half = (gc > 0) ? (gc - 1) / 2 : 0;
    // SystemVerilog division truncates toward zero, as the cell grid needs
    lox  = qx / div - half;
    loy  = qy / div - half;
    n    = (node_count_r > MAX_NODES) ? MAX_NODES : node_count_r;
    have = 1'b0;
    best = 0;
    r.nearest_index = '0;
    if (gc > 0) begin
      for (int i = 0; i < n; i++) begin
        if (tbl_dead[i]) continue;
        cx = tbl_x[i] / div;
        cy = tbl_y[i] / div;
        if (cx < lox || cx > lox + gc - 1 || cy < loy || cy > loy + gc - 1) continue;
        dx = qx - tbl_x[i];
        dy = qy - tbl_y[i];
        dz = qz - tbl_z[i];
        d2 = dx * dx + dy * dy + dz * dz;
        if (!have || d2 < best) begin
          have = 1'b1;
          best = d2;
          r.nearest_index = IDX_W'(i);
        end
      end
    end
    r.found = have;
    return r;
  endfunction

  // Driver: on each transfer update the node table or queue the predicted answer,
  // then offer the next pending item unless the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (offered.cmd == CMD_WRITE) begin
          tbl_x[offered.idx]    = longint'(offered.px);
          tbl_y[offered.idx]    = longint'(offered.py);
          tbl_z[offered.idx]    = longint'(offered.pz);
          tbl_dead[offered.idx] = offered.dead;
        end else begin
          hits_due.push_back(nearest_lookup(longint'(offered.px), longint'(offered.py),
                                            longint'(offered.pz)));
        end
      end
      // Hold the current item until it is taken; only then pick a new one.
      if (!in_tvalid || in_tready) begin
        if (items_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = items_waiting.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, offered.dead, offered.pz, offered.py, offered.px, offered.idx};
          in_tuser  <= offered.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then decide
  // whether to stall. In the pressure phase hold off once for a long stretch.
  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (hits_due.size() == 0) begin
          $error("result with nothing expected: nearest_index %0d found %0d",
                 out_tdata[IDX_W-1:0], out_tdata[IDX_W]);
          errors++;
        end else begin
          want = hits_due.pop_front();
          if (out_tdata[IDX_W-1:0] !== want.nearest_index) begin
            $error("nearest_index expected %0d actual %0d",
                   want.nearest_index, out_tdata[IDX_W-1:0]);
            errors++;
          end
          if (out_tdata[IDX_W] !== want.found) begin
            $error("found expected %0d actual %0d", want.found, out_tdata[IDX_W]);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (idle_mode == IDLE_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One register write; mirror it into the predictor's copy once taken.
  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRID_SIZE:  grid_size_r  = val & 16'hFFFF;
      CFG_GRID_COUNT: grid_count_r = val & 8'hFF;
      CFG_NODE_COUNT: node_count_r = val & 11'h7FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(int gs, int gc, int nc);
    write_reg(CFG_GRID_SIZE, gs);
    write_reg(CFG_GRID_COUNT, gc);
    write_reg(CFG_NODE_COUNT, nc);
  endtask

  task automatic set_idling(idle_mode_t m);
    idle_mode = m;
    case (m)
      IDLE_SEND: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      IDLE_BOTH: begin send_idle_pct = 27; recv_stall_pct = 27; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic push_write(int idx, longint x, longint y, longint z, bit dead);
    node_item_t it;
    it.cmd  = CMD_WRITE;
    it.idx  = IDX_W'(idx);
    it.px   = COORD_BITS'(x);
    it.py   = COORD_BITS'(y);
    it.pz   = COORD_BITS'(z);
    it.dead = dead;
    items_waiting.push_back(it);
    written[idx] = 1'b1;
    plan_x[idx]  = x;
    plan_y[idx]  = y;
    plan_z[idx]  = z;
  endtask

  task automatic push_query(longint x, longint y, longint z);
    node_item_t it;
    it.cmd  = CMD_QUERY;
    it.idx  = IDX_W'($urandom_range(MAX_NODES - 1));  // ignored on a query
    it.px   = COORD_BITS'(x);
    it.py   = COORD_BITS'(y);
    it.pz   = COORD_BITS'(z);
    it.dead = 1'($urandom_range(1));
    items_waiting.push_back(it);
  endtask

  // Mostly near the phase's cluster, sometimes anywhere, sometimes an extreme.
  function automatic longint pick_coord(longint c);
    longint v;
    int     r;
    r = $urandom_range(99);
    if (r < 70) begin
      v = c + longint'($urandom_range(32'(2 * spread))) - spread;
    end else if (r < 85) begin
      v = longint'($urandom_range(24'hFFFFFF)) - 64'sd8388608;
    end else begin
      case ($urandom_range(5))
        0:       v = COORD_MAX;
        1:       v = COORD_MIN;
        2:       v = 0;
        3:       v = -1;
        4:       v = 1;
        default: v = -16;
      endcase
    end
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v;
  endfunction

  // Fill any unwritten entry the scan will read, then mix writes and queries.
  task automatic random_phase(int count, int query_pct);
    int n_eff, hi_idx, pick, widx;
    int r;
    n_eff  = (node_count_r > MAX_NODES) ? MAX_NODES : node_count_r;
    hi_idx = (n_eff + 7 > MAX_NODES - 1) ? MAX_NODES - 1 : n_eff + 7;
    ctr_x  = longint'($urandom_range(8000000)) - 4000000;
    ctr_y  = longint'($urandom_range(8000000)) - 4000000;
    ctr_z  = longint'($urandom_range(8000000)) - 4000000;
    spread = longint'((grid_size_r == 0) ? 1 : grid_size_r) * 16 *
             ((grid_count_r == 0) ? 1 : grid_count_r);
    if (spread > 4000000) spread = 4000000;
    for (int i = 0; i < n_eff; i++)
      if (!written[i])
        push_write(i, pick_coord(ctr_x), pick_coord(ctr_y), pick_coord(ctr_z),
                   $urandom_range(3) == 0);
    repeat (count) begin
      if ($urandom_range(99) >= query_pct) begin
        widx = $urandom_range(hi_idx);
        if (n_eff > 0 && $urandom_range(9) == 0) begin
          // duplicate a stored position so distance ties show up
          pick = $urandom_range(n_eff - 1);
          push_write(widx, plan_x[pick], plan_y[pick], plan_z[pick], $urandom_range(3) == 0);
        end else begin
          push_write(widx, pick_coord(ctr_x), pick_coord(ctr_y), pick_coord(ctr_z),
                     $urandom_range(3) == 0);
        end
      end else begin
        r = $urandom_range(99);
        if (r < 75 || n_eff == 0 && r < 85) begin
          push_query(pick_coord(ctr_x), pick_coord(ctr_y), pick_coord(ctr_z));
        end else if (r < 85) begin
          pick = $urandom_range(n_eff - 1);
          push_query(plan_x[pick], plan_y[pick], plan_z[pick]);
        end else begin
          push_query(longint'($urandom_range(24'hFFFFFF)) - 64'sd8388608,
                     longint'($urandom_range(24'hFFFFFF)) - 64'sd8388608,
                     longint'($urandom_range(24'hFFFFFF)) - 64'sd8388608);
        end
      end
    end
  endtask

  // Wait until every item is taken and answered, then let trailing writes retire.
  task automatic drain();
    while (!(items_waiting.size() == 0 && !in_tvalid && hits_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table: nothing can be found.
    set_idling(IDLE_NONE);
    configure(4, 3, 0);
    push_query(10, 10, 0);
    // Entry 0 is dead and sits right on the first query; 2 and 5 share a spot;
    // 3 and 4 straddle the negative cell edge; 6 and 7 hold the extremes.
    push_write(0, 10, 10, 0, 1'b1);
    push_write(1, 100, 20, 5, 1'b0);
    push_write(2, 40, 40, 40, 1'b0);
    push_write(3, -63, -63, 0, 1'b0);
    push_write(4, -64, -64, 0, 1'b0);
    push_write(5, 40, 40, 40, 1'b0);
    push_write(6, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_write(7, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    drain();

    configure(4, 3, 8);
    push_query(10, 10, 0);          // skip the dead first candidate, tie goes low
    push_query(41, 40, 40);
    push_query(100, 20, 5);         // exact hit
    push_query(-64, -64, 0);        // cell below zero
    push_query(COORD_MAX, COORD_MAX, COORD_MAX);
    push_query(COORD_MIN, COORD_MIN, COORD_MIN);
    push_query(0, 5000, 0);         // empty window
    push_query(-1, -1, COORD_MIN);
    drain();

    // Zero grid count gives an empty window; zero grid size acts as one.
    configure(0, 0, 8);
    push_query(10, 10, 0);
    drain();
    configure(0, 2, 8);
    push_query(40, 40, 40);
    push_query(1, 1, 0);
    drain();
    configure(65535, 255, 8);
    push_query(0, 0, 0);
    push_query(COORD_MAX, COORD_MIN, 0);
    push_query(COORD_MIN, COORD_MAX, COORD_MAX);
    drain();

    // Random part, one register setting and idling pattern per phase.
    set_idling(IDLE_NONE);
    configure(1, 5, 16);
    random_phase(70, 55);
    drain();

    set_idling(IDLE_SEND);
    configure(3, 7, 32);
    random_phase(70, 55);
    drain();

    set_idling(IDLE_RECV);
    configure(65535, 255, 40);
    random_phase(70, 55);
    drain();

    set_idling(IDLE_BOTH);
    configure($urandom_range(200, 1), $urandom_range(9, 1), 48);
    random_phase(70, 55);
    drain();

    set_idling(IDLE_NONE);
    configure(0, 1, 64);
    random_phase(60, 55);
    drain();

    // Queries pile up behind a receiver that holds off for a long stretch.
    set_idling(IDLE_PRESSURE);
    configure(8, 15, 64);
    random_phase(60, 85);
    drain();

    set_idling(IDLE_BOTH);
    configure($urandom_range(65535, 1), $urandom_range(255), $urandom_range(64, 1));
    random_phase(70, 55);
    drain();

    if (hits_due.size() != 0) begin
      $error("%0d expected results never arrived", hits_due.size());
      errors++;
    end
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
